/* sv/spq_pkg.sv */
// spq_pkg: shared types and constants for the sorted priority queue.
// No dependencies; imported by every module of the block.
`default_nettype none

package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OCC_W    = 5;
    localparam int DATA_W   = 32;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd              cmd;
        logic [DATA_W-1:0] entry_id;
        logic [DATA_W-1:0] entry_score;
    } t_spq_in;

    typedef struct packed {
        logic [DATA_W-1:0] out_id;
        logic [DATA_W-1:0] out_score;
        logic              was_empty;
        logic              was_full;
        logic [OCC_W-1:0]  occupancy;
    } t_spq_out;

    typedef struct packed {
        logic [DATA_W-1:0] id;
        logic [DATA_W-1:0] score;
    } t_slot;

    // Shift controls broadcast to every cell.
    typedef struct packed {
        logic insert;
        logic remove;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* sv/spq_cell.sv */
// spq_cell: one slot of the sorted queue; holds an entry and shifts with its neighbors.
// Depends on spq_pkg.
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire t_slot     i_new,
    input  wire t_slot     i_left,
    input  wire t_slot     i_right,
    input  wire logic      i_left_keep,
    input  wire logic      i_occ,
    output t_slot          o_slot,
    output logic           o_keep
);

    t_slot r_slot;
    t_slot n_slot;

    // Stored entry stays put when it outranks or ties the new one.
    assign o_keep = i_occ && (r_slot.score >= i_new.score);
    assign o_slot = r_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_ctl.insert && !o_keep) begin
            n_slot = i_left_keep ? i_new : i_left;
        end else if (i_ctl.remove) begin
            n_slot = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.insert || i_ctl.remove) begin
            r_slot <= n_slot;
        end
    end

endmodule

`default_nettype wire

/* sv/sorted_priority_queue.sv */
// sorted_priority_queue: bounded max-priority queue built from a row of cells.
// Depends on spq_pkg and spq_cell.
//
// Usage:
//   Command channel: drive i_cmd and raise i_start; the beat is taken at a
//   rising edge with i_start high and o_busy low. o_busy stays low, so a
//   command may be issued every cycle.
//   Result channel: one result per command, shown on o_res for exactly one
//   cycle with o_done high, in the cycle after the command beat.
//   The receiver cannot stall; each result must be captured while o_done is up.
//   Throughput: one command per cycle. Every cell compares its score to the
//   incoming one in parallel and shifts by one slot.
//   Insert into a full queue is dropped with was_full; remove from an empty
//   queue returns zero data with was_empty. Equal scores leave first in,
//   first out.
//   Reset (i_rst_n low, synchronous) empties the queue and clears o_done;
//   slot contents are not cleared, only the entry count.
`default_nettype none

module sorted_priority_queue
    import spq_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_spq_in i_cmd,
    output logic         o_busy,
    output logic         o_done,
    output t_spq_out     o_res
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_done;
    t_spq_out         r_res;
    t_spq_out         n_res;

    logic             accept;
    logic             is_full;
    logic             is_empty;
    t_cell_ctl        ctl;
    t_slot            new_slot;

    t_slot            slots [CAPACITY];
    logic [CAPACITY-1:0] keep;
    logic [CAPACITY-1:0] occ;

    // Never busy: o_busy is tied low.
    assign o_busy   = 1'b0;
    assign accept   = i_start && !o_busy;
    assign is_full  = (r_count == CNT_W'(CAPACITY));
    assign is_empty = (r_count == '0);

    assign ctl.insert = accept && (i_cmd.cmd == CMD_INSERT) && !is_full;
    assign ctl.remove = accept && (i_cmd.cmd == CMD_REMOVE) && !is_empty;

    assign new_slot.id    = i_cmd.entry_id;
    assign new_slot.score = i_cmd.entry_score;

    // Cell row: slot 0 is the head (highest score).
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_slot left_slot;
        t_slot right_slot;
        logic  left_keep;

        assign occ[g] = (r_count > CNT_W'(g));

        if (g == 0) begin : g_head
            assign left_slot = new_slot;
            assign left_keep = 1'b1;
        end else begin : g_body
            assign left_slot = slots[g-1];
            assign left_keep = keep[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_slot = new_slot;   // vacated slot, content unused
        end else begin : g_mid
            assign right_slot = slots[g+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_new       (new_slot),
            .i_left      (left_slot),
            .i_right     (right_slot),
            .i_left_keep (left_keep),
            .i_occ       (occ[g]),
            .o_slot      (slots[g]),
            .o_keep      (keep[g])
        );
    end

    // Count update and result formation.
    always_comb begin
        n_count = r_count;
        if (ctl.insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctl.remove) begin
            n_count = r_count - CNT_W'(1);
        end

        n_res           = '0;
        n_res.occupancy = OCC_W'(n_count);
        if (ctl.remove) begin
            n_res.out_id    = slots[0].id;
            n_res.out_score = slots[0].score;
        end
        n_res.was_empty = (i_cmd.cmd == CMD_REMOVE) && is_empty;
        n_res.was_full  = (i_cmd.cmd == CMD_INSERT) && is_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

/* sv/spq_chk.sv */
// spq_chk: port-level checks for sorted_priority_queue, bound to the top level.
// Depends on spq_pkg.
`default_nettype none

module spq_chk
    import spq_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_start,
    input wire logic     o_busy,
    input wire logic     o_done,
    input wire t_spq_out o_res
);

    // Each accepted beat yields a result the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_done)
        else $error("spq: missing result after command beat");

    // No result without a command beat.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy))
        else $error("spq: result without command");

    // Empty remove reports an empty queue and zero data.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.was_empty) |->
            (o_res.occupancy == '0 && o_res.out_id == '0 && o_res.out_score == '0))
        else $error("spq: bad empty result");

    // A dropped insert only happens at capacity.
    a_full_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.was_full) |->
            (o_res.occupancy == OCC_W'(CAPACITY) && !o_res.was_empty))
        else $error("spq: bad full result");

    // Occupancy steps by at most one between back-to-back results.
    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(o_done)) |->
            (o_res.occupancy == $past(o_res.occupancy) ||
             o_res.occupancy == $past(o_res.occupancy) + OCC_W'(1) ||
             o_res.occupancy == $past(o_res.occupancy) - OCC_W'(1)))
        else $error("spq: occupancy jumped");

endmodule

bind sorted_priority_queue spq_chk u_spq_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_done  (o_done),
    .o_res   (o_res)
);

`default_nettype wire
